// ----- hw/rtl/rle4bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rle4bsd_pkg
// Shared types and constants for the RLE4 bitmap span decoder.
// ----------------------------------------------------------------------------
package rle4bsd_pkg;

  localparam int COORD_BITS = 10;
  // Wide enough for left + width and for any cursor value
  localparam int EDGE_BITS  = ((COORD_BITS > 11) ? COORD_BITS : 11) + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EDGE_BITS-1:0]  edge_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_TOP    = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic [9:0]  LEFT_RST   = 10'd0;
  localparam logic [9:0]  TOP_RST    = 10'd0;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;

  localparam edge_t  BOTTOM_SUM_RST = EDGE_BITS'(TOP_RST) + EDGE_BITS'(HEIGHT_RST)
                                      - EDGE_BITS'(1);
  localparam coord_t CURSOR_X_RST   = COORD_BITS'(LEFT_RST);
  localparam coord_t CURSOR_Y_RST   = COORD_BITS'(BOTTOM_SUM_RST);

  // Escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [3:0] NIBBLE_MASK  = 4'hF;
  localparam int         NIBBLE_SHIFT = 4;

  typedef enum logic [2:0] {
    PH_COUNT    = 3'd0,
    PH_COLOR    = 3'd1,
    PH_ESCAPE   = 3'd2,
    PH_DELTA_X  = 3'd3,
    PH_DELTA_Y  = 3'd4,
    PH_ABSOLUTE = 3'd5,
    PH_PAD      = 3'd6
  } phase_t;

  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  top;
    logic [10:0] width;
    logic [10:0] height;
  } window_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [7:0] length;
    logic [3:0] even_color;
    logic [3:0] odd_color;
    logic       done;
  } span_t;

endpackage

// ----- hw/rtl/rle4bsd_cfg.sv -----
// ----------------------------------------------------------------------------
// rle4bsd_cfg
// Window configuration registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module rle4bsd_cfg
  import rle4bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output window_t     win
);

  window_t win_r;

  assign cfg_ready = 1'b1;
  assign win       = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= LEFT_RST;
      win_r.top    <= TOP_RST;
      win_r.width  <= WIDTH_RST;
      win_r.height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEFT:   win_r.left   <= cfg_data[9:0];
        CFG_TOP:    win_r.top    <= cfg_data[9:0];
        CFG_WIDTH:  win_r.width  <= cfg_data;
        CFG_HEIGHT: win_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rle4bsd_decode.sv -----
// ----------------------------------------------------------------------------
// rle4bsd_decode
// Input register, parser state and the single-pass byte decode.
// ----------------------------------------------------------------------------
module rle4bsd_decode
  import rle4bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  window_t    win,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  input  logic       in_start_of_image,
  input  logic       res_room,
  output logic       res_load,
  output span_t      res
);

  // Input register
  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       hold_sof_r;

  // Parser state
  phase_t     phase_r,   phase_nxt;
  coord_t     cur_x_r,   cur_x_nxt;
  coord_t     cur_y_r,   cur_y_nxt;
  logic [7:0] run_r,     run_nxt;
  logic [7:0] abs_r,     abs_nxt;
  logic       pad_r,     pad_nxt;
  logic       fin_r,     fin_nxt;

  // State after an optional restart
  phase_t     ph_e;
  coord_t     cx_e, cy_e;
  logic [7:0] run_e, abs_e;
  logic       pad_e, fin_e;

  logic [3:0] hi, lo;
  logic [7:0] abs_take, abs_rem, clip_n, clip_len;
  logic [8:0] cnt_inc;
  edge_t      right_edge, avail, start_y;
  logic       emit, take;

  assign hi = 4'(hold_byte_r >> NIBBLE_SHIFT) & NIBBLE_MASK;
  assign lo = hold_byte_r[3:0] & NIBBLE_MASK;

  assign start_y = EDGE_BITS'(win.top) + EDGE_BITS'(win.height) - EDGE_BITS'(1);

  always_comb begin
    if (hold_sof_r) begin
      ph_e  = PH_COUNT;
      cx_e  = COORD_BITS'(win.left);
      cy_e  = COORD_BITS'(start_y);
      run_e = '0;
      abs_e = '0;
      pad_e = 1'b0;
      fin_e = 1'b0;
    end else begin
      ph_e  = phase_r;
      cx_e  = cur_x_r;
      cy_e  = cur_y_r;
      run_e = run_r;
      abs_e = abs_r;
      pad_e = pad_r;
      fin_e = fin_r;
    end
  end

  assign abs_take = (abs_e < 8'd2) ? abs_e : 8'd2;
  assign abs_rem  = abs_e - abs_take;
  assign cnt_inc  = {1'b0, hold_byte_r} + 9'd1;

  // Right-edge clip of the pending span
  assign clip_n     = (ph_e == PH_COLOR) ? run_e : abs_take;
  assign right_edge = EDGE_BITS'(win.left) + EDGE_BITS'(win.width);
  assign avail      = right_edge - EDGE_BITS'(cx_e);
  always_comb begin
    if (EDGE_BITS'(cx_e) >= right_edge) begin
      clip_len = '0;
    end else if (avail < EDGE_BITS'(clip_n)) begin
      clip_len = avail[7:0];
    end else begin
      clip_len = clip_n;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = ph_e;
    if (!fin_e) begin
      unique case (ph_e)
        PH_COLOR:    phase_nxt = PH_COUNT;
        PH_ESCAPE: begin
          if (hold_byte_r == ESC_EOL || hold_byte_r == ESC_EOB) begin
            phase_nxt = PH_COUNT;
          end else if (hold_byte_r == ESC_DELTA) begin
            phase_nxt = PH_DELTA_X;
          end else begin
            phase_nxt = PH_ABSOLUTE;
          end
        end
        PH_DELTA_X:  phase_nxt = PH_DELTA_Y;
        PH_DELTA_Y:  phase_nxt = PH_COUNT;
        PH_ABSOLUTE: begin
          if (abs_rem == '0) begin
            phase_nxt = pad_e ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD:      phase_nxt = PH_COUNT;
        default:     phase_nxt = (hold_byte_r != '0) ? PH_COLOR : PH_ESCAPE;
      endcase
    end
  end

  // Cursor, counters and result
  always_comb begin
    cur_x_nxt      = cx_e;
    cur_y_nxt      = cy_e;
    run_nxt        = run_e;
    abs_nxt        = abs_e;
    pad_nxt        = pad_e;
    fin_nxt        = fin_e;
    emit           = 1'b0;
    res.x          = cx_e;
    res.y          = cy_e;
    res.length     = clip_len;
    res.even_color = hi;
    res.odd_color  = lo;
    res.done       = 1'b0;
    if (!fin_e) begin
      case (ph_e)
        PH_COLOR, PH_ABSOLUTE: begin
          if (ph_e == PH_ABSOLUTE) begin
            abs_nxt = abs_rem;
          end
          if (clip_len != '0) begin
            emit      = 1'b1;
            cur_x_nxt = cx_e + COORD_BITS'(clip_len);
          end
        end
        PH_ESCAPE: begin
          if (hold_byte_r == ESC_EOL) begin
            cur_x_nxt = COORD_BITS'(win.left);
            cur_y_nxt = cy_e - COORD_BITS'(1);
          end else if (hold_byte_r == ESC_EOB) begin
            fin_nxt        = 1'b1;
            emit           = 1'b1;
            res.length     = '0;
            res.even_color = '0;
            res.odd_color  = '0;
            res.done       = 1'b1;
          end else if (hold_byte_r != ESC_DELTA) begin
            abs_nxt = hold_byte_r;
            pad_nxt = cnt_inc[1];
          end
        end
        PH_DELTA_X: cur_x_nxt = cx_e + COORD_BITS'(hold_byte_r);
        PH_DELTA_Y: cur_y_nxt = cy_e - COORD_BITS'(hold_byte_r);
        PH_PAD:     pad_nxt   = 1'b0;
        default: begin
          if (hold_byte_r != '0) begin
            run_nxt = hold_byte_r;
          end
        end
      endcase
    end
  end

  // Advance the held byte unless its span has nowhere to go
  assign take     = hold_valid_r && (!emit || res_room);
  assign res_load = take && emit;
  assign in_stall = hold_valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid_r <= 1'b1;
    end else if (take) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte_r <= in_stream_byte;
      hold_sof_r  <= in_start_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      cur_x_r <= CURSOR_X_RST;
      cur_y_r <= CURSOR_Y_RST;
      run_r   <= '0;
      abs_r   <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      run_r   <= run_nxt;
      abs_r   <= abs_nxt;
      pad_r   <= pad_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ----- hw/rtl/rle4bsd_out.sv -----
// ----------------------------------------------------------------------------
// rle4bsd_out
// Result register holding one span until the receiver takes it.
// ----------------------------------------------------------------------------
module rle4bsd_out
  import rle4bsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  res_load,
  input  span_t res,
  output logic  res_room,
  output logic  out_valid,
  input  logic  out_stall,
  output span_t out_span
);

  logic  valid_r;
  span_t span_r;

  // Room when empty or when the held span leaves this cycle
  assign res_room  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_span  = span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      span_r <= res;
    end
  end

endmodule

// ----- hw/rtl/rle4_bitmap_span_decoder.sv -----
// ----------------------------------------------------------------------------
// rle4_bitmap_span_decoder
// BMP RLE4 stream decoder producing clipped horizontal pixel spans.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one compressed byte per transfer (in_valid / in_stall);
//   in_start_of_image restarts at the window's bottom-left first.
//   Output channel: at most one span per byte (out_valid / out_stall);
//   bytes that only move the cursor or are clipped away give no span.
//   The end-of-bitmap escape gives one span with image_done set and
//   zero length; later bytes are dropped until a restart.
//   Configuration: cfg_valid / cfg_ready write window registers by index
//   (0 left, 1 top, 2 width, 3 height); write only while idle.
//   Path: each byte is held in the input register, decoded, and its span
//   is loaded into the result register, from which it is offered; a full
//   result register keeps the byte waiting in the input register.
//   Throughput: one byte per cycle while its span finds room; the parse
//   state loop closes through the decode logic alone.
//   Stall: a stalled span holds in the result register; the next byte is
//   still taken and decoded, and waits in the input register only if it
//   too yields a span.
//   Reset: window back to 0, 0, 640 x 480, cursor to column 0, row 479,
//   both channels empty.
// ----------------------------------------------------------------------------
module rle4_bitmap_span_decoder
  import rle4bsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_stream_byte,
  input  logic              in_start_of_image,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        out_span_x,
  output logic [9:0]        out_span_y,
  output logic [7:0]        out_span_length,
  output logic [3:0]        out_even_color,
  output logic [3:0]        out_odd_color,
  output logic              out_image_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data
);

  window_t win;
  span_t   res, out_span;
  logic    res_room, res_load;

  rle4bsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  rle4bsd_decode u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .win               (win),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .in_start_of_image (in_start_of_image),
    .res_room          (res_room),
    .res_load          (res_load),
    .res               (res)
  );

  rle4bsd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_room  (res_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_span  (out_span)
  );

  assign out_span_x      = 10'(out_span.x);
  assign out_span_y      = 10'(out_span.y);
  assign out_span_length = out_span.length;
  assign out_even_color  = out_span.even_color;
  assign out_odd_color   = out_span.odd_color;
  assign out_image_done  = out_span.done;

endmodule
